>>> src/aefp_pkg.sv
package aefp_pkg;

    localparam int ANG_W   = 16;
    localparam int GAIN_W  = 12;
    localparam int FIELD_W = 18;
    localparam int CFG_W   = 16;

    localparam int SC_W    = 34;
    localparam int AT_IN_W = 36;
    localparam int AT_W    = 38;
    localparam int AT_OUT_W = 33;

    localparam int CORDIC_STEPS = 24;
    localparam int ISQRT_STEPS  = 32;
    localparam int EXP_STEPS    = 16;
    localparam int AMP_W        = 28;

    localparam longint TURN_QUARTER    = 64'sd1073741824;
    localparam longint TURN_HALF       = 64'sd2147483648;
    localparam longint CORDIC_INV_GAIN = 64'sd652032874;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd1272;

    localparam int ATAN_TAB [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef enum logic [1:0] {
        CFG_BEARING,
        CFG_DOWNTILT,
        CFG_GAIN,
        CFG_ISO
    } t_cfg_idx;

    // Repeated square roots of two in Q30, each an integer square root.
    function automatic logic [31:0] exp2_root(input int k);
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        c = 64'd1 << 31;
        for (int j = 0; j < k; j++) begin
            v   = c << 30;
            res = '0;
            b   = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            c = res;
        end
        return c[31:0];
    endfunction

endpackage

>>> src/aefp_in_if.sv
interface aefp_in_if import aefp_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic [ANG_W-1:0]        zenith_angle;
    logic signed [ANG_W-1:0] azimuth_angle;

    modport source(output valid, output zenith_angle, output azimuth_angle, input ready);
    modport sink(input valid, input zenith_angle, input azimuth_angle, output ready);
endinterface

>>> src/aefp_out_if.sv
interface aefp_out_if import aefp_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] field_phi;
    logic signed [FIELD_W-1:0] field_theta;

    modport source(output valid, output field_phi, output field_theta, input ready);
    modport sink(input valid, input field_phi, input field_theta, output ready);
endinterface

>>> src/aefp_delay.sv
module aefp_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_sr [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int i = 1; i < D; i++) begin
                r_sr[i] <= r_sr[i-1];
            end
        end
    end

    assign o_d = r_sr[D-1];
endmodule

>>> src/aefp_sincos.sv
module aefp_sincos import aefp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [31:0]            i_ang,
    output logic signed [SC_W-1:0] o_cos,
    output logic signed [SC_W-1:0] o_sin
);
    localparam logic signed [SC_W-1:0] SC_QTR  = SC_W'(TURN_QUARTER);
    localparam logic signed [SC_W-1:0] SC_HALF = SC_W'(TURN_HALF);
    localparam logic signed [SC_W-1:0] SC_GAIN = SC_W'(CORDIC_INV_GAIN);

    logic signed [SC_W-1:0] r_x [CORDIC_STEPS+1];
    logic signed [SC_W-1:0] r_y [CORDIC_STEPS+1];
    logic signed [SC_W-1:0] r_z [CORDIC_STEPS+1];
    logic                   r_neg [CORDIC_STEPS+1];
    logic signed [SC_W-1:0] r_cos;
    logic signed [SC_W-1:0] r_sin;
    logic signed [SC_W-1:0] w_ang;
    logic signed [SC_W-1:0] n_z;
    logic                   n_neg;

    always_comb begin
        w_ang = {{(SC_W-32){i_ang[31]}}, i_ang};
        n_z   = w_ang;
        n_neg = 1'b0;
        if (w_ang > SC_QTR) begin
            n_z   = w_ang - SC_HALF;
            n_neg = 1'b1;
        end else if (w_ang < -SC_QTR) begin
            n_z   = w_ang + SC_HALF;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= SC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= n_z;
            r_neg[0] <= n_neg;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - SC_W'(ATAN_TAB[i]);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + SC_W'(ATAN_TAB[i]);
                end
                r_neg[i+1] <= r_neg[i];
            end
            r_cos <= r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
            r_sin <= r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;
endmodule

>>> src/aefp_atan2.sv
module aefp_atan2 import aefp_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [AT_IN_W-1:0]  i_x,
    input  logic signed [AT_IN_W-1:0]  i_y,
    output logic signed [AT_OUT_W-1:0] o_ang
);
    localparam logic signed [AT_W-1:0] AT_HALF = AT_W'(TURN_HALF);

    logic signed [AT_W-1:0]     r_x [CORDIC_STEPS+1];
    logic signed [AT_W-1:0]     r_y [CORDIC_STEPS+1];
    logic signed [AT_W-1:0]     r_z [CORDIC_STEPS+1];
    logic                       r_zero [CORDIC_STEPS+1];
    logic signed [AT_OUT_W-1:0] r_ang;
    logic signed [AT_W-1:0]     w_x;
    logic signed [AT_W-1:0]     w_y;
    logic [31:0]                w_wrap;

    assign w_x    = AT_W'(i_x);
    assign w_y    = AT_W'(i_y);
    assign w_wrap = r_z[CORDIC_STEPS][31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -w_x;
                r_y[0] <= -w_y;
                r_z[0] <= AT_HALF;
            end else begin
                r_x[0] <= w_x;
                r_y[0] <= w_y;
                r_z[0] <= '0;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + AT_W'(ATAN_TAB[i]);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - AT_W'(ATAN_TAB[i]);
                end
                r_zero[i+1] <= r_zero[i];
            end
            if (r_zero[CORDIC_STEPS]) begin
                r_ang <= '0;
            end else if (w_wrap == 32'h8000_0000) begin
                r_ang <= {1'b0, w_wrap};
            end else begin
                r_ang <= {w_wrap[31], w_wrap};
            end
        end
    end

    assign o_ang = r_ang;
endmodule

>>> src/aefp_isqrt.sv
module aefp_isqrt import aefp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_v,
    output logic [30:0] o_root
);
    logic [63:0] r_v [ISQRT_STEPS];
    logic [63:0] r_r [ISQRT_STEPS];
    logic [63:0] t_v [ISQRT_STEPS];
    logic [63:0] t_r [ISQRT_STEPS];

    always_comb begin
        t_v[0] = 64'(i_v);
        t_r[0] = '0;
        for (int i = 1; i < ISQRT_STEPS; i++) begin
            t_v[i] = r_v[i-1];
            t_r[i] = r_r[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ISQRT_STEPS; i++) begin
                if (t_v[i] >= t_r[i] + (64'd1 << (62 - 2 * i))) begin
                    r_v[i] <= t_v[i] - (t_r[i] + (64'd1 << (62 - 2 * i)));
                    r_r[i] <= (t_r[i] >> 1) + (64'd1 << (62 - 2 * i));
                end else begin
                    r_v[i] <= t_v[i];
                    r_r[i] <= t_r[i] >> 1;
                end
            end
        end
    end

    assign o_root = r_r[ISQRT_STEPS-1][30:0];
endmodule

>>> src/aefp_exp2.sv
module aefp_exp2 import aefp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [21:0] i_e,
    output logic [AMP_W-1:0]   o_amp
);
    logic [31:0]       c_root [1:EXP_STEPS];
    logic [30:0]       r_r [EXP_STEPS+1];
    logic [15:0]       r_f [EXP_STEPS+1];
    logic signed [5:0] r_n [EXP_STEPS+1];
    logic [AMP_W-1:0]  r_amp;
    logic [30:0]       w_r;
    logic signed [5:0] w_n;
    logic [3:0]        w_up;
    logic [6:0]        w_down;
    logic [39:0]       w_wide;
    logic [AMP_W-1:0]  n_amp;

    for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_root
        localparam logic [31:0] ROOT_K = exp2_root(k);
        assign c_root[k] = ROOT_K;
    end

    assign w_r = r_r[EXP_STEPS];
    assign w_n = r_n[EXP_STEPS];

    always_comb begin
        w_up   = (w_n > 6'sd8) ? 4'd8 : 4'(w_n);
        w_down = 7'd6 - {w_n[5], w_n};
        w_wide = 40'(w_r);
        if (!w_n[5]) begin
            n_amp = AMP_W'((w_wide << w_up) >> 6);
        end else begin
            n_amp = AMP_W'(w_wide >> w_down);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0] <= 31'd1 << 30;
            r_f[0] <= i_e[15:0];
            r_n[0] <= i_e[21:16];
            for (int k = 1; k <= EXP_STEPS; k++) begin
                if (r_f[k-1][16-k]) begin
                    r_r[k] <= 31'((63'(r_r[k-1]) * 63'(c_root[k])) >> 30);
                end else begin
                    r_r[k] <= r_r[k-1];
                end
                r_f[k] <= r_f[k-1];
                r_n[k] <= r_n[k-1];
            end
            r_amp <= n_amp;
        end
    end

    assign o_amp = r_amp;
endmodule

>>> src/antenna_element_field_pattern_top.sv
// Throughput: one word per cycle; the pipeline stalls as a whole only when
// the output register and its skid register are both full.
// Reset (synchronous, active low) clears all valid bits and loads the
// configuration defaults: bearing 0, downtilt 0, gain 1272, isotropic off.
module antenna_element_field_pattern_top import aefp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    aefp_in_if.sink          i_in,
    aefp_out_if.source       o_out
);
    localparam int LAT = 117;
    localparam int MQ_W = 36;
    localparam logic [31:0]        CUT_BIG    = 32'd332267689;
    localparam logic [29:0]        CUT_RECIP  = 30'd813248246;
    localparam logic [20:0]        CUT_LIMIT  = 21'd1966080;
    localparam logic [15:0]        CUT_NUM    = 16'd62208;
    localparam logic signed [22:0] LOG_K      = 23'sd2786635;
    localparam logic signed [36:0] Q30_POS    = 37'sd1073741824;

    function automatic logic signed [MQ_W-1:0] mulq(input logic signed [MQ_W-1:0] a,
                                                    input logic signed [MQ_W-1:0] b);
        logic signed [2*MQ_W-1:0] p;
        p = a * b;
        return MQ_W'(p >>> 30);
    endfunction

    function automatic logic signed [FIELD_W-1:0] round_sat(input logic signed [62:0] p);
        logic signed [62:0] t;
        t = (p + (63'sd1 <<< 38)) >>> 39;
        if (t > 63'sd131071) begin
            return 18'sd131071;
        end else if (t < -63'sd131072) begin
            return -18'sd131072;
        end
        return FIELD_W'(t);
    endfunction

    logic [ANG_W-1:0]  r_bearing;
    logic [ANG_W-1:0]  r_downtilt;
    logic [GAIN_W-1:0] r_gain;
    logic              r_iso;

    logic             w_en;
    logic [LAT-1:0]   r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bearing  <= '0;
            r_downtilt <= '0;
            r_gain     <= GAIN_RESET;
            r_iso      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BEARING:  r_bearing  <= i_cfg_data;
                CFG_DOWNTILT: r_downtilt <= i_cfg_data;
                CFG_GAIN:     r_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_ISO:      r_iso      <= i_cfg_data[0];
                default:      r_iso      <= r_iso;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    logic [ANG_W-1:0]       w_dphi;
    logic signed [SC_W-1:0] w_ct, w_st, w_cb, w_sb, w_cd, w_sd;

    assign w_dphi = i_in.azimuth_angle - r_bearing;

    aefp_sincos u_sc_theta (
        .i_clk(i_clk), .i_en(w_en), .i_ang({i_in.zenith_angle, 16'h0000}),
        .o_cos(w_ct), .o_sin(w_st)
    );
    aefp_sincos u_sc_tilt (
        .i_clk(i_clk), .i_en(w_en), .i_ang({r_downtilt, 16'h0000}),
        .o_cos(w_cb), .o_sin(w_sb)
    );
    aefp_sincos u_sc_dphi (
        .i_clk(i_clk), .i_en(w_en), .i_ang({w_dphi, 16'h0000}),
        .o_cos(w_cd), .o_sin(w_sd)
    );

    logic signed [MQ_W-1:0] r_a1, r_a2, r_a3, r_a4, r_a5, r_a6, r_st1, r_cd1;
    logic signed [MQ_W-1:0] r_b1, r_b2, r_b3, r_a1_2, r_a3_2, r_a4_2, r_a5_2, r_a6_2;
    logic signed [31:0]     r_carg3, r_carg4, r_carg5;
    logic signed [MQ_W-1:0] r_ppx3, r_ppy3, r_psx3, r_psy3;
    logic signed [MQ_W-1:0] r_ppx4, r_ppy4, r_psx4, r_psy4;
    logic signed [MQ_W-1:0] r_ppx5, r_ppy5, r_psx5, r_psy5;
    logic [63:0]            r_sq;
    logic [60:0]            r_v;
    logic signed [36:0]     w_sum;

    assign w_sum = 37'(r_a1_2) + 37'(r_b1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a1  <= mulq(MQ_W'(w_cb), MQ_W'(w_ct));
            r_a2  <= mulq(MQ_W'(w_sb), MQ_W'(w_cd));
            r_a3  <= mulq(MQ_W'(w_sd), MQ_W'(w_st));
            r_a4  <= mulq(MQ_W'(w_cb), MQ_W'(w_st));
            r_a5  <= mulq(MQ_W'(w_sb), MQ_W'(w_ct));
            r_a6  <= mulq(MQ_W'(w_sb), MQ_W'(w_sd));
            r_st1 <= MQ_W'(w_st);
            r_cd1 <= MQ_W'(w_cd);

            r_b1   <= mulq(r_a2, r_st1);
            r_b2   <= mulq(r_a4, r_cd1);
            r_b3   <= mulq(r_a5, r_cd1);
            r_a1_2 <= r_a1;
            r_a3_2 <= r_a3;
            r_a4_2 <= r_a4;
            r_a5_2 <= r_a5;
            r_a6_2 <= r_a6;

            if (w_sum > Q30_POS) begin
                r_carg3 <= 32'(Q30_POS);
            end else if (w_sum < -Q30_POS) begin
                r_carg3 <= -32'(Q30_POS);
            end else begin
                r_carg3 <= 32'(w_sum);
            end
            r_ppx3 <= r_b2 - r_a5_2;
            r_ppy3 <= r_a3_2;
            r_psx3 <= r_a4_2 - r_b3;
            r_psy3 <= r_a6_2;

            r_sq    <= 64'(64'(r_carg3) * 64'(r_carg3));
            r_carg4 <= r_carg3;
            r_ppx4  <= r_ppx3;
            r_ppy4  <= r_ppy3;
            r_psx4  <= r_psx3;
            r_psy4  <= r_psy3;

            r_v     <= 61'((64'd1 << 60) - r_sq);
            r_carg5 <= r_carg4;
            r_ppx5  <= r_ppx4;
            r_ppy5  <= r_ppy4;
            r_psx5  <= r_psx4;
            r_psy5  <= r_psy4;
        end
    end

    logic [30:0]             w_root;
    logic [32+4*MQ_W-1:0]    w_side;
    logic signed [31:0]      w_carg_d;
    logic signed [MQ_W-1:0]  w_ppx_d, w_ppy_d, w_psx_d, w_psy_d;

    aefp_isqrt u_isqrt (
        .i_clk(i_clk), .i_en(w_en), .i_v(r_v), .o_root(w_root)
    );

    aefp_delay #(.W(32 + 4 * MQ_W), .D(ISQRT_STEPS)) u_side_dly (
        .i_clk(i_clk), .i_en(w_en),
        .i_d({r_carg5, r_ppx5, r_ppy5, r_psx5, r_psy5}),
        .o_d(w_side)
    );

    assign {w_carg_d, w_ppx_d, w_ppy_d, w_psx_d, w_psy_d} = w_side;

    logic signed [AT_OUT_W-1:0] w_tp, w_pp, w_psi;

    aefp_atan2 u_at_theta (
        .i_clk(i_clk), .i_en(w_en),
        .i_x(AT_IN_W'(w_carg_d)), .i_y(AT_IN_W'({1'b0, w_root})),
        .o_ang(w_tp)
    );
    aefp_atan2 u_at_phi (
        .i_clk(i_clk), .i_en(w_en),
        .i_x(AT_IN_W'(w_ppx_d)), .i_y(AT_IN_W'(w_ppy_d)),
        .o_ang(w_pp)
    );
    aefp_atan2 u_at_psi (
        .i_clk(i_clk), .i_en(w_en),
        .i_x(AT_IN_W'(w_psx_d)), .i_y(AT_IN_W'(w_psy_d)),
        .o_ang(w_psi)
    );

    logic signed [SC_W-1:0] w_cp, w_sp;

    aefp_sincos u_sc_psi (
        .i_clk(i_clk), .i_en(w_en), .i_ang(w_psi[31:0]),
        .o_cos(w_cp), .o_sin(w_sp)
    );

    logic signed [34:0] w_dt;
    logic [34:0]        w_adt;
    logic [32:0]        w_app;
    logic [23:0]        r_v1, r_v2;
    logic [47:0]        r_s1, r_s2;
    logic [63:0]        r_n1, r_n2;
    logic [28:0]        r_m1, r_m2;
    logic               r_big1, r_big2;
    logic [20:0]        r_q1, r_q2;
    logic [21:0]        w_tot;
    logic [21:0]        w_totc;
    logic signed [22:0] r_db;
    logic signed [45:0] r_prod;

    assign w_dt   = 35'(w_tp) - 35'(TURN_QUARTER);
    assign w_adt  = w_dt[34] ? 35'(-w_dt) : 35'(w_dt);
    assign w_app  = w_pp[32] ? 33'(-w_pp) : 33'(w_pp);
    assign w_tot  = 22'(r_q1) + 22'(r_q2);
    assign w_totc = (w_tot > 22'(CUT_LIMIT)) ? 22'(CUT_LIMIT) : w_tot;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v1 <= 24'(w_adt >> 8);
            r_v2 <= 24'(w_app >> 8);

            r_s1 <= 48'(r_v1) * 48'(r_v1);
            r_s2 <= 48'(r_v2) * 48'(r_v2);

            r_n1 <= 64'(r_s1) * 64'(CUT_NUM);
            r_n2 <= 64'(r_s2) * 64'(CUT_NUM);

            r_big1 <= r_n1[63:32] >= CUT_BIG;
            r_big2 <= r_n2[63:32] >= CUT_BIG;
            r_m1   <= r_n1[60:32];
            r_m2   <= r_n2[60:32];

            r_q1 <= r_big1 ? CUT_LIMIT : 21'((59'(r_m1) * 59'(CUT_RECIP)) >> 37);
            r_q2 <= r_big2 ? CUT_LIMIT : 21'((59'(r_m2) * 59'(CUT_RECIP)) >> 37);

            if (r_iso) begin
                r_db <= '0;
            end else begin
                r_db <= 23'({r_gain, 8'h00}) - 23'(w_totc);
            end

            r_prod <= 46'(r_db) * 46'(LOG_K);
        end
    end

    logic [AMP_W-1:0] w_amp, w_amp_d;

    aefp_exp2 u_exp2 (
        .i_clk(i_clk), .i_en(w_en), .i_e(22'(r_prod >>> 24)), .o_amp(w_amp)
    );

    aefp_delay #(.W(AMP_W), .D(1)) u_amp_dly (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_amp), .o_d(w_amp_d)
    );

    logic signed [62:0]        r_pphi, r_pth;
    logic signed [FIELD_W-1:0] r_phi, r_theta;
    logic signed [AMP_W:0]     w_amp_s;

    assign w_amp_s = {1'b0, w_amp_d};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pphi  <= 63'(w_amp_s) * 63'(w_sp);
            r_pth   <= 63'(w_amp_s) * 63'(w_cp);
            r_phi   <= round_sat(r_pphi);
            r_theta <= round_sat(r_pth);
        end
    end

    logic                      r_out_v, r_skid_v, w_take;
    logic signed [FIELD_W-1:0] r_out_phi, r_out_theta, r_skid_phi, r_skid_theta;

    assign w_en   = !r_skid_v;
    assign w_take = r_vld[LAT-1] && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_out.ready) begin
            if (r_skid_v) begin
                r_out_v     <= 1'b1;
                r_out_phi   <= r_skid_phi;
                r_out_theta <= r_skid_theta;
                r_skid_v    <= 1'b0;
            end else begin
                r_out_v <= w_take;
                if (w_take) begin
                    r_out_phi   <= r_phi;
                    r_out_theta <= r_theta;
                end
            end
        end else if (w_take) begin
            r_skid_v     <= 1'b1;
            r_skid_phi   <= r_phi;
            r_skid_theta <= r_theta;
        end
    end

    assign i_in.ready        = w_en;
    assign o_out.valid       = r_out_v;
    assign o_out.field_phi   = r_out_phi;
    assign o_out.field_theta = r_out_theta;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("Skid register holds a word while the output register is empty.");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("Accepted word did not enter the first pipeline stage.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("Pipeline valid bits moved during a stall.");
endmodule
